[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL; each use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/core/gfide_pkg.sv]
// ----------------------------------------------------------------------------
// gfide_pkg
// Types, constants and GF(2^8) helpers for the dispersal encoder.
// ----------------------------------------------------------------------------
package gfide_pkg;

  localparam int ROW_REGS  = 5;   // coefficient row registers
  localparam int ROW_W     = 24;  // bits per row register
  localparam int CFG_IDX_W = 3;   // configuration index width

  // reduction polynomial x^8+x^6+x^5+x^4+1
  localparam logic [8:0] GF_POLY = 9'h171;

  localparam logic [ROW_W-1:0] ROW_RESET [ROW_REGS] = '{
    24'h313332, 24'h313131, 24'h323331, 24'h323233, 24'h323333
  };

  typedef logic [7:0] byte_t;

  // group bookkeeping that travels with the bytes of a finished group
  typedef struct packed {
    logic       last;     // group closed by end_of_stream
    logic [1:0] excess;   // byte count mod group size
  } grp_tag_t;

  // one share byte transaction
  typedef struct packed {
    logic [2:0] share_index;
    byte_t      share_byte;
    logic       group_last;
    logic       stream_done;
    logic [1:0] excess;
  } result_t;

  // carry-less multiply reduced by GF_POLY, shift-and-add form
  function automatic byte_t gf_mul(byte_t a, byte_t b);
    logic [8:0] x;
    byte_t      r;
    x = {1'b0, a};
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ GF_POLY;
    end
    return r;
  endfunction

  // coefficient byte of a row; slot 0 is bits 7:0, slots past 23:16 are zero
  function automatic byte_t coeff_pick(logic [ROW_W-1:0] row, int slot);
    byte_t c;
    case (slot)
      0:       c = row[7:0];
      1:       c = row[15:8];
      2:       c = row[23:16];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/gf256_information_dispersal_encoder.sv]
// Path: a group enters the group queue when the byte that closes it is taken; its share
// bytes follow through the result queue one per cycle while the result queue is not full.
// Throughput: one source byte per cycle in bursts while the group queue is not full;
// sustained, the single share datapath gives SHARE_COUNT results per group.
// Reset (rst, synchronous): empties both queues, clears the group position and
// the share counter, and loads the coefficient rows with their defaults.
// ----------------------------------------------------------------------------
// gf256_information_dispersal_encoder
// GF(2^8) information dispersal encoder: byte groups in, share bytes out.
// ----------------------------------------------------------------------------
module gf256_information_dispersal_encoder import gfide_pkg::*; #(
  parameter int SHARE_COUNT = 5,
  parameter int GROUP_SIZE  = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           share_index,
  output logic [7:0]           share_byte,
  output logic                 group_last,
  output logic                 stream_done,
  output logic [1:0]           excess,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  localparam int GRP_W = GROUP_SIZE * 8 + $bits(grp_tag_t);

  logic                   g_push;
  byte_t [GROUP_SIZE-1:0] g_bytes_in;
  grp_tag_t               g_tag_in;
  logic                   g_full;
  logic                   g_pop;
  logic                   g_empty;
  logic [GRP_W-1:0]       g_rdata;
  byte_t [GROUP_SIZE-1:0] g_bytes_out;
  grp_tag_t               g_tag_out;
  logic                   r_push;
  logic                   r_full;
  result_t                r_in;
  result_t                r_out;

  assign cfg_ready = 1'b1;

  gfide_front #(.GROUP_SIZE(GROUP_SIZE)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .full          (full),
    .grp_push      (g_push),
    .grp_bytes     (g_bytes_in),
    .grp_tag       (g_tag_in),
    .grp_full      (g_full)
  );

  // queue of finished groups between gather and share stages
  gfide_fifo #(.WIDTH(GRP_W)) u_grp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (g_push),
    .wdata ({g_bytes_in, g_tag_in}),
    .full  (g_full),
    .pop   (g_pop),
    .rdata (g_rdata),
    .empty (g_empty)
  );

  assign {g_bytes_out, g_tag_out} = g_rdata;

  gfide_back #(.SHARE_COUNT(SHARE_COUNT), .GROUP_SIZE(GROUP_SIZE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grp_empty (g_empty),
    .grp_bytes (g_bytes_out),
    .grp_tag   (g_tag_out),
    .grp_pop   (g_pop),
    .res_push  (r_push),
    .res       (r_in),
    .res_full  (r_full)
  );

  // result queue drives the output ports
  gfide_fifo #(.WIDTH($bits(result_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_in),
    .full  (r_full),
    .pop   (pop),
    .rdata (r_out),
    .empty (empty)
  );

  assign share_index = r_out.share_index;
  assign share_byte  = r_out.share_byte;
  assign group_last  = r_out.group_last;
  assign stream_done = r_out.stream_done;
  assign excess      = r_out.excess;

endmodule

[rtl/core/gfide_fifo.sv]
// ----------------------------------------------------------------------------
// gfide_fifo
// Two-entry register queue; decouples the gather and share stages and buffers the results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfide_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop)  rptr <= !rptr;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  `ASSERT_NEVER(a_fifo_overfill, cnt == 2'd3, "fifo count beyond depth")
  `ASSERT_CLK(a_fifo_fill, (empty && push) |=> !empty, "push into empty fifo lost")

endmodule

[rtl/core/gfide_front.sv]
// ----------------------------------------------------------------------------
// gfide_front
// Gathers source bytes into groups, zero pads a group closed early and
// tags it with end-of-stream and the byte count mod group size.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfide_front import gfide_pkg::*; #(
  parameter int GROUP_SIZE = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  byte_t                      data_byte,
  input  logic                       end_of_stream,
  output logic                       full,
  output logic                       grp_push,
  output byte_t [GROUP_SIZE-1:0]     grp_bytes,
  output grp_tag_t                   grp_tag,
  input  logic                       grp_full
);

  localparam int PW = $clog2(GROUP_SIZE);
  localparam int FW = $clog2(GROUP_SIZE + 1);

  byte_t          held [GROUP_SIZE-1];
  logic [PW-1:0]  pos;
  logic [FW-1:0]  filled;
  logic           accept;
  logic           closing;

  assign full    = grp_full;
  assign accept  = push && !grp_full;
  assign filled  = FW'(pos) + FW'(1);
  assign closing = (pos == PW'(GROUP_SIZE - 1)) || end_of_stream;
  assign grp_push = accept && closing;

  // assemble the group: held bytes, the new byte, zeros after it
  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      grp_bytes[j] = (pos == PW'(j)) ? data_byte : '0;
    end
    for (int j = 0; j < GROUP_SIZE - 1; j++) begin
      if (PW'(j) < pos) grp_bytes[j] = held[j];
    end
    grp_tag.last   = end_of_stream;
    grp_tag.excess = end_of_stream && (filled != FW'(GROUP_SIZE)) ? 2'(filled) : 2'd0;
  end

  // group position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= closing ? '0 : pos + PW'(1);
    end
  end

  // byte hold registers
  always_ff @(posedge clk) begin
    if (accept && !closing) begin
      for (int j = 0; j < GROUP_SIZE - 1; j++) begin
        if (pos == PW'(j)) held[j] <= data_byte;
      end
    end
  end

  `ASSERT_CLK(a_front_restart, (accept && closing) |=> (pos == '0), "group not restarted")

endmodule

[rtl/core/gfide_back.sv]
// ----------------------------------------------------------------------------
// gfide_back
// Holds the coefficient rows and walks the shares of a queued group,
// one GF(2^8) dot product per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfide_back import gfide_pkg::*; #(
  parameter int SHARE_COUNT = 5,
  parameter int GROUP_SIZE  = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ROW_W-1:0]       cfg_data,
  input  logic                   grp_empty,
  input  byte_t [GROUP_SIZE-1:0] grp_bytes,
  input  grp_tag_t               grp_tag,
  output logic                   grp_pop,
  output logic                   res_push,
  output result_t                res,
  input  logic                   res_full
);

  logic [ROW_W-1:0] rows [ROW_REGS];
  logic [ROW_W-1:0] row;
  logic [2:0]       cnt;
  logic             last_share;
  logic             fire;
  byte_t            acc;

  assign last_share = (cnt == 3'(SHARE_COUNT - 1));
  assign fire       = !grp_empty && !res_full;
  assign grp_pop    = fire && last_share;
  assign res_push   = fire;

  // coefficient row of the current share; shares past the registers are zero
  always_comb begin
    row = '0;
    for (int r = 0; r < ROW_REGS; r++) begin
      if (cnt == 3'(r)) row = rows[r];
    end
  end

  // dot product over the group
  always_comb begin
    acc = '0;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      acc = acc ^ gf_mul(coeff_pick(row, GROUP_SIZE - 1 - j), grp_bytes[j]);
    end
  end

  always_comb begin
    res.share_index = cnt;
    res.share_byte  = acc;
    res.group_last  = last_share;
    res.stream_done = grp_tag.last;
    res.excess      = grp_tag.last ? grp_tag.excess : 2'd0;
  end

  // share counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= last_share ? '0 : cnt + 3'd1;
    end
  end

  // coefficient registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_REGS; r++) rows[r] <= ROW_RESET[r];
    end else if (cfg_valid) begin
      for (int r = 0; r < ROW_REGS; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) rows[r] <= cfg_data;
      end
    end
  end

  `ASSERT_CLK(a_back_range, cnt <= 3'(SHARE_COUNT - 1), "share counter out of range")
  `ASSERT_CLK(a_back_idle, grp_empty |-> (cnt == '0), "share walk without a group")

endmodule
